>>> sv/lru_pkg.sv
// Shared types and constants for the LRU replacement list.
// No dependencies; every other file of the block uses this package.
package lru_pkg;

  // Payload widths of the request and response beats
  localparam int unsigned OP_W      = 2;
  localparam int unsigned FRAME_W   = 6;
  localparam int unsigned ENTRIES_W = 7;

  // Default pool size
  localparam int unsigned NUM_FRAMES_DEF = 64;

  // Operation codes carried in the opcode field
  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_VICTIM = 2'd1,
    OP_ERASE  = 2'd2
  } op_e;

  // Per-beat controls broadcast to every cell of the row
  typedef struct packed {
    logic               match_en;  // look for frame among held entries
    logic               ins;       // append frame at the most-recent end
    logic [FRAME_W-1:0] fid;       // frame of the request
  } cell_ctl_t;

endpackage

>>> sv/lru_if.sv
// Valid/ready channel interfaces for request and response beats.
// Depends on lru_pkg for payload widths.
interface lru_req_if;
  logic                        valid;
  logic                        ready;
  logic [lru_pkg::OP_W-1:0]    opcode;
  logic [lru_pkg::FRAME_W-1:0] frame_id;

  modport source (output valid, output opcode, output frame_id, input ready);
  modport sink   (input valid, input opcode, input frame_id, output ready);
endinterface

interface lru_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          success;
  logic [lru_pkg::FRAME_W-1:0]   victim_frame;
  logic [lru_pkg::ENTRIES_W-1:0] entries_held;

  modport source (output valid, output success, output victim_frame,
                  output entries_held, input ready);
  modport sink   (input valid, input success, input victim_frame,
                  input entries_held, output ready);
endinterface

>>> sv/lru_cell.sv
// One position of the recency row: a frame id and an occupied flag.
// Depends on lru_pkg; instantiated in a row by lru_replacement_list.
module lru_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lru_pkg::cell_ctl_t          ctl_i,
  input  logic                        hit_i,       // frame found somewhere in the row
  input  logic                        seen_i,      // removal point at or before left neighbor
  output logic                        seen_o,
  input  logic                        prev_occ_i,  // left neighbor occupied
  input  logic [lru_pkg::FRAME_W-1:0] next_val_i,  // right neighbor entry
  input  logic                        next_occ_i,
  output logic [lru_pkg::FRAME_W-1:0] val_o,
  output logic                        occ_o
);

  logic [lru_pkg::FRAME_W-1:0] val_q, val_d;
  logic                        occ_q, occ_d;
  logic                        match;
  logic                        shift;
  logic                        tail;

  // Detect the requested frame and pass the removal point rightward
  assign match  = ctl_i.match_en && occ_q && (val_q == ctl_i.fid);
  assign seen_o = seen_i || match;
  assign shift  = seen_o && occ_q;

  // Append target: last held slot after a removal, else first free slot
  assign tail = ctl_i.ins &&
                (hit_i ? (occ_q && !next_occ_i) : (!occ_q && prev_occ_i));

  // Close the gap by taking the right neighbor, then place an append
  always_comb begin
    val_d = val_q;
    occ_d = occ_q;
    if (tail) begin
      val_d = ctl_i.fid;
      occ_d = 1'b1;
    end else if (shift) begin
      val_d = next_val_i;
      occ_d = next_occ_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;
  assign occ_o = occ_q;

endmodule

>>> sv/lru_replacement_list.sv
// LRU replacement list: accepts one request beat per clock cycle unless a response stalls and
// returns one response beat per request, registered, in the cycle after acceptance; a response
// waiting in the output register is no stall if the sink takes it in the same cycle. The held
// frames sit in a row of NUM_FRAMES cells, least recent at cell 0; each beat updates the whole
// row at once, every cell taking its right neighbor's entry from the removal point onward, so
// the cycle is set by the frame-match chain along the row. Reset needs no clearing pass.
// Depends on lru_pkg, lru_if and lru_cell.
module lru_replacement_list #(
  parameter int unsigned NUM_FRAMES = lru_pkg::NUM_FRAMES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  lru_req_if.sink       req_i,
  lru_rsp_if.source     rsp_o
);

  localparam int unsigned CNT_W = $clog2(NUM_FRAMES + 1);

  logic                        fire;
  logic                        fid_ok;
  logic                        hit;
  logic                        pop;
  lru_pkg::cell_ctl_t          ctl;
  logic [NUM_FRAMES:0]         seen;
  logic [lru_pkg::FRAME_W-1:0] val [NUM_FRAMES];
  logic [NUM_FRAMES-1:0]       occ;

  logic [CNT_W-1:0]            count_q, count_d;
  logic                        rsp_valid_q;
  logic                        success_q, success_d;
  logic [lru_pkg::FRAME_W-1:0] victim_q, victim_d;

  // Accept a request whenever the output register is free or draining
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign fire        = req_i.valid && req_i.ready;
  assign fid_ok      = (32'(req_i.frame_id) < NUM_FRAMES);

  // Decode the request into row controls
  always_comb begin
    ctl.fid      = req_i.frame_id;
    ctl.match_en = 1'b0;
    ctl.ins      = 1'b0;
    pop          = 1'b0;
    case (lru_pkg::op_e'(req_i.opcode))
      lru_pkg::OP_INSERT: begin
        ctl.match_en = fire && fid_ok;
        ctl.ins      = fire && fid_ok;
      end
      lru_pkg::OP_VICTIM: begin
        pop = fire;
      end
      lru_pkg::OP_ERASE: begin
        ctl.match_en = fire && fid_ok;
      end
      default: begin
      end
    endcase
  end

  // Row of cells; a pop starts the removal point at the head
  assign seen[0] = pop;
  assign hit     = seen[NUM_FRAMES] && ctl.match_en;

  for (genvar i = 0; i < NUM_FRAMES; i++) begin : g_cell
    logic                        prev_occ;
    logic [lru_pkg::FRAME_W-1:0] next_val;
    logic                        next_occ;

    if (i == 0) begin : g_head
      assign prev_occ = 1'b1;
    end else begin : g_mid
      assign prev_occ = occ[i-1];
    end

    if (i == NUM_FRAMES - 1) begin : g_last
      assign next_val = '0;
      assign next_occ = 1'b0;
    end else begin : g_inner
      assign next_val = val[i+1];
      assign next_occ = occ[i+1];
    end

    lru_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .hit_i      (hit),
      .seen_i     (seen[i]),
      .seen_o     (seen[i+1]),
      .prev_occ_i (prev_occ),
      .next_val_i (next_val),
      .next_occ_i (next_occ),
      .val_o      (val[i]),
      .occ_o      (occ[i])
    );
  end

  // Work out the count and the response fields
  always_comb begin
    count_d   = count_q;
    success_d = 1'b0;
    victim_d  = '0;
    case (lru_pkg::op_e'(req_i.opcode))
      lru_pkg::OP_INSERT: begin
        success_d = fid_ok;
        if (fid_ok && !hit) begin
          count_d = count_q + CNT_W'(1);
        end
      end
      lru_pkg::OP_VICTIM: begin
        if (occ[0]) begin
          success_d = 1'b1;
          victim_d  = val[0];
          count_d   = count_q - CNT_W'(1);
        end
      end
      lru_pkg::OP_ERASE: begin
        if (hit) begin
          success_d = 1'b1;
          count_d   = count_q - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Hold control state; the count advances only on an accepted beat, the valid flag whenever ready
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        count_q <= count_d;
      end
      if (req_i.ready) begin
        rsp_valid_q <= fire;
      end
    end
  end

  // Capture the response payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      success_q <= success_d;
      victim_q  <= victim_d;
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.success      = success_q;
  assign rsp_o.victim_frame = victim_q;
  assign rsp_o.entries_held = lru_pkg::ENTRIES_W'(count_q);

endmodule

>>> sv/lru_checker.sv
// Port-level checks on the LRU replacement list, attached by bind.
// Depends on lru_pkg and on the ports of lru_replacement_list.
module lru_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          req_valid_i,
  input logic                          req_ready_i,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic                          rsp_success_i,
  input logic [lru_pkg::FRAME_W-1:0]   rsp_victim_i,
  input logic [lru_pkg::ENTRIES_W-1:0] rsp_entries_i
);

  logic                          have_last_q;
  logic [lru_pkg::ENTRIES_W-1:0] last_q;

  // Track the count of the last delivered beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_last_q <= 1'b0;
      last_q      <= '0;
    end else if (rsp_valid_i && rsp_ready_i) begin
      have_last_q <= 1'b1;
      last_q      <= rsp_entries_i;
    end
  end

  // A stalled response beat holds its payload
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_success_i) &&
      $stable(rsp_victim_i) && $stable(rsp_entries_i))
    else $error("response beat changed while stalled");

  // Each accepted request yields a response in the next cycle
  a_req_to_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> rsp_valid_i)
    else $error("accepted request produced no response");

  // A stalled response blocks new requests
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |-> !req_ready_i)
    else $error("request taken while response stalled");

  // Count moves by at most one between successive responses
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && have_last_q |->
      (rsp_entries_i == last_q) || (rsp_entries_i == last_q + 7'd1) ||
      (rsp_entries_i + 7'd1 == last_q))
    else $error("count jumped by more than one");

endmodule

bind lru_replacement_list lru_checker u_lru_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_success_i (rsp_o.success),
  .rsp_victim_i  (rsp_o.victim_frame),
  .rsp_entries_i (rsp_o.entries_held)
);
